>>> rtl/core/ccc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_pkg: calendar clock counter shared definitions
// Operation codes, time fields, start time and the month length table.
// ----------------------------------------------------------------------------
package ccc_pkg;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_ADD       = 2'd1,
    OP_CLR_FLAGS = 2'd2,
    OP_CLR_TIME  = 2'd3
  } op_e;

  // calendar fields above the millisecond count
  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [2:0]  wday;
    logic [3:0]  month;
    logic [15:0] year;
  } date_t;

  localparam logic [10:0] MS_LAST    = 11'd999;
  localparam logic [5:0]  SEC_LAST   = 6'd59;
  localparam logic [5:0]  MIN_LAST   = 6'd59;
  localparam logic [4:0]  HOUR_LAST  = 5'd23;
  localparam logic [2:0]  WDAY_LAST  = 3'd7;
  localparam logic [3:0]  MONTH_LAST = 4'd12;
  localparam logic [3:0]  FEB        = 4'd2;
  localparam logic [4:0]  LEAP_DAY   = 5'd29;

  localparam logic [1:0] MS_FLAG_NONE = 2'd0;
  localparam logic [1:0] MS_FLAG_ANY  = 2'd1;
  localparam logic [1:0] MS_FLAG_TEN  = 2'd2;
  localparam logic [1:0] MS_FLAG_HUND = 2'd3;

  localparam date_t DATE_START = '{
    sec:   6'd0,
    min:   6'd0,
    hour:  5'd0,
    day:   5'd1,
    wday:  3'd1,
    month: 4'd1,
    year:  16'd2010
  };

  localparam logic [4:0] MONTH_LEN [16] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31,
    5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31
  };

endpackage

>>> rtl/core/ccc_ms_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_ms_unit: millisecond stage
// Next millisecond count, sticky display flag and the carry into seconds.
// ----------------------------------------------------------------------------
module ccc_ms_unit (
  input  ccc_pkg::op_e  op_i,
  input  logic [7:0]    step_ms_i,
  input  logic [10:0]   ms_q_i,
  input  logic [1:0]    ms_flag_q_i,
  output logic [10:0]   ms_d_o,
  output logic [1:0]    ms_flag_d_o,
  output logic          sec_carry_o
);
  import ccc_pkg::*;

  logic [10:0] ms_inc;
  logic [18:0] prod10;
  logic [17:0] prod100;
  logic [6:0]  quo10;
  logic [3:0]  quo100;
  logic [10:0] back10;
  logic [10:0] back100;
  logic        mul10;
  logic        mul100;
  logic        tick_wrap;
  logic [11:0] sum;
  logic        add_wrap;
  logic [1:0]  tick_flag;

  assign ms_inc = ms_q_i + 11'd1;

  // divide by 10 and 100 through reciprocal multiply, exact for counts up to 1000
  assign prod10  = {8'd0, ms_inc} * 19'd205;
  assign prod100 = {7'd0, ms_inc} * 18'd41;
  assign quo10   = prod10[17:11];
  assign quo100  = prod100[15:12];
  assign back10  = {1'b0, quo10, 3'd0} + {3'd0, quo10, 1'b0};
  assign back100 = {1'b0, quo100, 6'd0} + {2'd0, quo100, 5'd0} + {5'd0, quo100, 2'd0};
  assign mul10   = (back10 == ms_inc);
  assign mul100  = (back100 == ms_inc);
  assign tick_wrap = mul100 && (ms_inc > MS_LAST);

  assign sum      = {1'b0, ms_q_i} + {4'd0, step_ms_i};
  assign add_wrap = (sum > {1'b0, MS_LAST});

  always_comb begin
    if (mul100) begin
      tick_flag = MS_FLAG_HUND;
    end else if (mul10) begin
      tick_flag = MS_FLAG_TEN;
    end else if (ms_flag_q_i == MS_FLAG_NONE) begin
      tick_flag = MS_FLAG_ANY;
    end else begin
      tick_flag = ms_flag_q_i;
    end
  end

  always_comb begin
    ms_d_o      = ms_q_i;
    ms_flag_d_o = ms_flag_q_i;
    sec_carry_o = 1'b0;
    unique case (op_i)
      OP_TICK: begin
        ms_d_o      = tick_wrap ? 11'd0 : ms_inc;
        ms_flag_d_o = tick_flag;
        sec_carry_o = tick_wrap;
      end
      OP_ADD: begin
        // excess past one second is dropped
        ms_d_o      = add_wrap ? 11'd0 : sum[10:0];
        sec_carry_o = add_wrap;
      end
      OP_CLR_FLAGS: begin
        ms_flag_d_o = MS_FLAG_NONE;
      end
      OP_CLR_TIME: begin
        ms_d_o = 11'd0;
      end
      default: begin
        ms_d_o = ms_q_i;
      end
    endcase
  end

endmodule

>>> rtl/core/ccc_date_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_date_unit: calendar carry chain
// Ripples a second carry through minutes, hours, days, months and years.
// ----------------------------------------------------------------------------
module ccc_date_unit (
  input  ccc_pkg::op_e   op_i,
  input  logic           sec_carry_i,
  input  ccc_pkg::date_t date_q_i,
  input  logic [3:0]     unit_flags_q_i,
  output ccc_pkg::date_t date_d_o,
  output logic [3:0]     unit_flags_d_o
);
  import ccc_pkg::*;

  logic [5:0]  sec_inc;
  logic [5:0]  min_inc;
  logic [4:0]  hour_inc;
  logic [4:0]  day_inc;
  logic [2:0]  wday_inc;
  logic [3:0]  month_inc;
  logic [4:0]  month_len;
  logic        sec_wrap;
  logic        min_wrap;
  logic        hour_wrap;
  logic        leap_extra;
  logic        day_over;
  logic        month_wrap;
  date_t       adv;

  assign sec_inc   = date_q_i.sec + 6'd1;
  assign min_inc   = date_q_i.min + 6'd1;
  assign hour_inc  = date_q_i.hour + 5'd1;
  assign day_inc   = date_q_i.day + 5'd1;
  assign wday_inc  = date_q_i.wday + 3'd1;
  assign month_inc = date_q_i.month + 4'd1;
  assign month_len = MONTH_LEN[date_q_i.month - 4'd1];

  assign sec_wrap  = sec_carry_i && (sec_inc > SEC_LAST);
  assign min_wrap  = sec_wrap && (min_inc > MIN_LAST);
  assign hour_wrap = min_wrap && (hour_inc > HOUR_LAST);

  // february of a year divisible by four keeps day 29
  assign leap_extra = (date_q_i.month == FEB) && (date_q_i.year[1:0] == 2'd0) &&
                      (day_inc == LEAP_DAY);
  // compared before the increment, day 31 plus one does not fit the field
  assign day_over   = (date_q_i.day >= month_len) && !leap_extra;
  assign month_wrap = hour_wrap && day_over && (month_inc > MONTH_LAST);

  always_comb begin
    adv = date_q_i;
    if (sec_carry_i) begin
      adv.sec = sec_wrap ? 6'd0 : sec_inc;
    end
    if (sec_wrap) begin
      adv.min = min_wrap ? 6'd0 : min_inc;
    end
    if (min_wrap) begin
      adv.hour = hour_wrap ? 5'd0 : hour_inc;
    end
    if (hour_wrap) begin
      adv.wday = (date_q_i.wday >= WDAY_LAST) ? 3'd1 : wday_inc;
      adv.day  = day_over ? 5'd1 : day_inc;
      if (day_over) begin
        adv.month = month_wrap ? 4'd1 : month_inc;
      end
    end
    if (month_wrap) begin
      adv.year = date_q_i.year + 16'd1;
    end
  end

  always_comb begin
    date_d_o       = adv;
    unit_flags_d_o = unit_flags_q_i | {hour_wrap, min_wrap, sec_wrap, sec_carry_i};
    unique case (op_i)
      OP_CLR_FLAGS: begin
        unit_flags_d_o = 4'd0;
      end
      OP_CLR_TIME: begin
        date_d_o       = DATE_START;
        unit_flags_d_o = unit_flags_q_i;
      end
      OP_TICK, OP_ADD: begin
        date_d_o = adv;
      end
      default: begin
        date_d_o = adv;
      end
    endcase
  end

endmodule

>>> rtl/core/calendar_clock_counter.sv
`timescale 1ns / 1ps
// an accepted transaction goes to the input register and then updates the time
// registers, which also hold the result; throughput: one transaction per cycle
// while the receiver takes results, a held result stalls the input
// reset: time is 2010-01-01 00:00:00.000, weekday 1, flags cleared, no result
// pending
// ----------------------------------------------------------------------------
// calendar_clock_counter: millisecond through year calendar clock
// Ticks, steps, clears flags or restarts the time, one result per item.
// ----------------------------------------------------------------------------
module calendar_clock_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  step_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [10:0] millis_o,
  output logic [5:0]  secs_o,
  output logic [5:0]  mins_o,
  output logic [4:0]  hrs_o,
  output logic [4:0]  day_of_month_o,
  output logic [2:0]  weekday_o,
  output logic [3:0]  month_num_o,
  output logic [15:0] year_num_o,
  output logic [1:0]  ms_flag_o,
  output logic [3:0]  unit_flags_o
);
  import ccc_pkg::*;

  logic        in_valid_q;
  op_e         op_q;
  logic [7:0]  step_q;
  logic        out_valid_q;
  logic        advance;

  logic [10:0] ms_q, ms_d;
  logic [1:0]  ms_flag_q, ms_flag_d;
  logic [3:0]  unit_flags_q, unit_flags_d;
  date_t       date_q, date_d;
  logic        sec_carry;

  // the state registers are the result register; they move only when it frees up
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q   <= op_e'(operation_i);
      step_q <= step_ms_i;
    end
  end

  ccc_ms_unit u_ms (
    .op_i        (op_q),
    .step_ms_i   (step_q),
    .ms_q_i      (ms_q),
    .ms_flag_q_i (ms_flag_q),
    .ms_d_o      (ms_d),
    .ms_flag_d_o (ms_flag_d),
    .sec_carry_o (sec_carry)
  );

  ccc_date_unit u_date (
    .op_i           (op_q),
    .sec_carry_i    (sec_carry),
    .date_q_i       (date_q),
    .unit_flags_q_i (unit_flags_q),
    .date_d_o       (date_d),
    .unit_flags_d_o (unit_flags_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      ms_q         <= 11'd0;
      ms_flag_q    <= MS_FLAG_NONE;
      unit_flags_q <= 4'd0;
      date_q       <= DATE_START;
    end else begin
      if (advance) begin
        out_valid_q  <= 1'b1;
        ms_q         <= ms_d;
        ms_flag_q    <= ms_flag_d;
        unit_flags_q <= unit_flags_d;
        date_q       <= date_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign millis_o       = ms_q;
  assign secs_o         = date_q.sec;
  assign mins_o         = date_q.min;
  assign hrs_o          = date_q.hour;
  assign day_of_month_o = date_q.day;
  assign weekday_o      = date_q.wday;
  assign month_num_o    = date_q.month;
  assign year_num_o     = date_q.year;
  assign ms_flag_o      = ms_flag_q;
  assign unit_flags_o   = unit_flags_q;

`ifndef NO_ASSERTIONS
  // millisecond count never passes the last value of a second
  a_ms_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ms_q <= MS_LAST)
    else $error("millisecond count out of range");

  // input side only blocks behind a held result with work waiting
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a held result");

  // a held result keeps the time unchanged
  a_hold_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> ($stable(ms_q) && $stable(date_q) &&
                                       $stable(unit_flags_q) && $stable(ms_flag_q)))
    else $error("time changed while a result was held");

  // calendar fields stay in their ranges
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (date_q.wday != 3'd0) && (date_q.day != 5'd0) && (date_q.month != 4'd0) &&
    (date_q.month <= MONTH_LAST) && (date_q.hour <= HOUR_LAST))
    else $error("calendar field out of range");
`endif

endmodule

>>> verif/tb_calendar_clock_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calendar_clock_counter: self-checking bench for the calendar clock counter
// Sends ticks, steps, flag clears and time clears over the valid/ready input.
// A tracker class keeps its own copy of the calendar, works out the time and
// flags after every accepted transaction and compares each result field by
// field. A run of maximum steps drives the second and minute carries.
// ----------------------------------------------------------------------------

import ccc_pkg::*;

// rollover bit positions in unit_flags
localparam int UF_SEC  = 0;
localparam int UF_MIN  = 1;
localparam int UF_HOUR = 2;
localparam int UF_DATE = 3;

localparam int MAX_REPORTS = 40;

typedef struct packed {
  logic [10:0] millis;
  logic [5:0]  secs;
  logic [5:0]  mins;
  logic [4:0]  hrs;
  logic [4:0]  mday;
  logic [2:0]  wday;
  logic [3:0]  month;
  logic [15:0] year;
  logic [1:0]  ms_flag;
  logic [3:0]  unit_flags;
} clock_view_t;

class calendar_tracker;
  logic [10:0]   ms;
  logic [5:0]    sec;
  logic [5:0]    minute;
  logic [4:0]    hour;
  logic [4:0]    mday;
  logic [2:0]    wday;
  logic [3:0]    month;
  logic [15:0]   year;
  logic [1:0]    ms_flag;
  logic [3:0]    unit_flags;
  clock_view_t   expected_times[$];
  int            errors;

  function new();
    restart_time();
    ms_flag    = MS_FLAG_NONE;
    unit_flags = '0;
    errors     = 0;
  endfunction

  function void restart_time();
    ms     = '0;
    sec    = '0;
    minute = '0;
    hour   = '0;
    mday   = 5'd1;
    wday   = 3'd1;
    month  = 4'd1;
    year   = 16'd2010;
  endfunction

  function void advance_second();
    logic [4:0] month_days;
    unit_flags[UF_SEC] = 1'b1;
    if (sec != SEC_LAST) begin
      sec = sec + 6'd1;
      return;
    end
    sec = '0;
    unit_flags[UF_MIN] = 1'b1;
    if (minute != MIN_LAST) begin
      minute = minute + 6'd1;
      return;
    end
    minute = '0;
    unit_flags[UF_HOUR] = 1'b1;
    if (hour != HOUR_LAST) begin
      hour = hour + 5'd1;
      return;
    end
    hour = '0;
    unit_flags[UF_DATE] = 1'b1;
    wday = (wday == WDAY_LAST) ? 3'd1 : wday + 3'd1;
    case (month)
      4'd2:                   month_days = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: month_days = 5'd30;
      default:                month_days = 5'd31;
    endcase
    // leap february keeps day 29, no century rule
    if (mday >= month_days &&
        !(month == FEB && year[1:0] == 2'b00 && mday + 5'd1 == LEAP_DAY)) begin
      mday = 5'd1;
      if (month == MONTH_LAST) begin
        month = 4'd1;
        year  = year + 16'd1;
      end else begin
        month = month + 4'd1;
      end
    end else begin
      mday = mday + 5'd1;
    end
  endfunction

  function void apply_item(op_e op, logic [7:0] step);
    case (op)
      OP_TICK: begin
        ms = ms + 11'd1;
        if (ms % 10 == 0) begin
          ms_flag = MS_FLAG_TEN;
          if (ms % 100 == 0) begin
            ms_flag = MS_FLAG_HUND;
            if (ms > MS_LAST) begin
              ms = '0;
              advance_second();
            end
          end
        end
        if (ms_flag == MS_FLAG_NONE) ms_flag = MS_FLAG_ANY;
      end
      OP_ADD: begin
        // overflow past 999 drops the excess
        ms = ms + {3'b000, step};
        if (ms > MS_LAST) begin
          ms = '0;
          advance_second();
        end
      end
      OP_CLR_FLAGS: begin
        ms_flag    = MS_FLAG_NONE;
        unit_flags = '0;
      end
      default: restart_time();
    endcase
    expected_times.push_back({ms, sec, minute, hour, mday, wday, month, year,
                              ms_flag, unit_flags});
  endfunction

  function void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      if (errors < MAX_REPORTS) $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function void check_result(clock_view_t got);
    clock_view_t want;
    if (expected_times.size() == 0) begin
      if (errors < MAX_REPORTS) $error("result transaction with nothing pending");
      errors++;
      return;
    end
    want = expected_times.pop_front();
    compare_field("millis", want.millis, got.millis);
    compare_field("secs", want.secs, got.secs);
    compare_field("mins", want.mins, got.mins);
    compare_field("hrs", want.hrs, got.hrs);
    compare_field("day_of_month", want.mday, got.mday);
    compare_field("weekday", want.wday, got.wday);
    compare_field("month_num", want.month, got.month);
    compare_field("year_num", want.year, got.year);
    compare_field("ms_flag", want.ms_flag, got.ms_flag);
    compare_field("unit_flags", want.unit_flags, got.unit_flags);
  endfunction

  function int outstanding();
    return expected_times.size();
  endfunction
endclass

module tb_calendar_clock_counter;

  localparam int     CLK_PERIOD   = 20;
  localparam int     RANDOM_ITEMS = 1400;
  // a little over a minute of 255 ms steps, four steps per second
  localparam int     CARRY_STEPS  = 4 * 60 + 60;
  localparam int     DRAIN_CYCLES = 10;
  localparam longint CYCLE_LIMIT  = 2_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  op_e         operation;
  logic [7:0]  step_ms;
  logic        out_valid;
  logic        out_ready;
  logic [10:0] millis;
  logic [5:0]  secs;
  logic [5:0]  mins;
  logic [4:0]  hrs;
  logic [4:0]  mday;
  logic [2:0]  wday;
  logic [3:0]  month_num;
  logic [15:0] year_num;
  logic [1:0]  ms_flag;
  logic [3:0]  unit_flags;
  clock_view_t seen;

  calendar_tracker tracker;
  longint          cycle_count;
  int              hold_request;
  bit              rx_free;

  calendar_clock_counter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .operation_i    (operation),
    .step_ms_i      (step_ms),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .millis_o       (millis),
    .secs_o         (secs),
    .mins_o         (mins),
    .hrs_o          (hrs),
    .day_of_month_o (mday),
    .weekday_o      (wday),
    .month_num_o    (month_num),
    .year_num_o     (year_num),
    .ms_flag_o      (ms_flag),
    .unit_flags_o   (unit_flags)
  );

  assign seen = {millis, secs, mins, hrs, mday, wday, month_num, year_num,
                 ms_flag, unit_flags};

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[calendar_clock_counter] ERROR");
      $finish;
    end
  end

  // input transaction is noted before the result check of the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) tracker.apply_item(operation, step_ms);
      if (out_valid && out_ready) tracker.check_result(seen);
    end
  end

  // receiver: stall pattern changes per segment, long hold on request
  initial begin
    int mode;
    int seg_left;
    int hold_left;
    out_ready = 1'b0;
    mode      = 0;
    seg_left  = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 3);
        seg_left = $urandom_range(20, 200);
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_free || mode == 0) begin
        out_ready <= 1'b1;
      end else if (mode == 1) begin
        out_ready <= 1'($urandom_range(0, 1));
      end else if (mode == 2) begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end else begin
        out_ready <= ~out_ready;
      end
    end
  end

  task automatic send_item(input op_e op, input logic [7:0] step);
    in_valid  <= 1'b1;
    operation <= op;
    step_ms   <= step;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (tracker.outstanding() != 0);
  endtask

  initial begin
    int         burst_left;
    int         tick_run;
    int         pick;
    logic [7:0] step;
    tracker      = new();
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    operation    = OP_TICK;
    step_ms      = '0;
    hold_request = 0;
    rx_free      = 1'b0;
    burst_left   = 0;
    tick_run     = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: flag order, step overflow, clears
    send_item(OP_TICK, 8'd0);
    send_item(OP_ADD, 8'd0);
    send_item(OP_ADD, 8'd255);
    send_item(OP_ADD, 8'd255);
    send_item(OP_ADD, 8'd255);
    send_item(OP_ADD, 8'd234);
    send_item(OP_TICK, 8'd255);
    send_item(OP_CLR_FLAGS, 8'd0);
    send_item(OP_TICK, 8'd0);
    send_item(OP_ADD, 8'd8);
    send_item(OP_TICK, 8'd0);
    send_item(OP_ADD, 8'd89);
    send_item(OP_TICK, 8'd0);
    send_item(OP_ADD, 8'd255);
    send_item(OP_ADD, 8'd255);
    send_item(OP_ADD, 8'd255);
    send_item(OP_ADD, 8'd255);
    send_item(OP_CLR_TIME, 8'd255);
    send_item(OP_ADD, 8'd255);
    send_item(OP_CLR_FLAGS, 8'd255);
    send_item(OP_TICK, 8'd0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // long receiver hold while the sender keeps offering
      if (i == 400) begin
        hold_request = 300;
        burst_left   = 400;
      end
      if (i == 1000) wait_for_results();
      if (burst_left == 0) begin
        pause_sender($urandom_range(0, 8));
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      if (tick_run == 0 && $urandom_range(0, 19) == 0) tick_run = $urandom_range(10, 150);
      if (tick_run > 0) begin
        tick_run--;
        send_item(OP_TICK, 8'($urandom));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          send_item(OP_TICK, 8'($urandom));
        end else if (pick < 82) begin
          case ($urandom_range(0, 7))
            0:       step = 8'd0;
            1:       step = 8'd255;
            default: step = 8'($urandom_range(0, 255));
          endcase
          send_item(OP_ADD, step);
        end else if (pick < 95) begin
          send_item(OP_CLR_FLAGS, 8'($urandom));
        end else begin
          send_item(OP_CLR_TIME, 8'($urandom));
        end
      end
    end

    // maximum steps at full rate to reach the minute carry
    wait_for_results();
    rx_free = 1'b1;
    send_item(OP_CLR_TIME, 8'd0);
    for (int i = 0; i < CARRY_STEPS; i++) begin
      if (i % 100 == 99) send_item(OP_CLR_FLAGS, 8'd0);
      send_item(OP_ADD, 8'd255);
    end
    rx_free = 1'b0;

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("[calendar_clock_counter] OK");
    end else begin
      $display("[calendar_clock_counter] ERROR");
    end
    $finish;
  end

endmodule
